// ----- rtl/core/gtr_pkg.sv -----
package gtr_pkg;

  localparam int unsigned GlyphWidth  = 5;
  localparam int unsigned GlyphHeight = 6;
  localparam int unsigned GlyphGap    = 2;
  localparam int unsigned GlyphPitch  = GlyphWidth + GlyphGap;
  localparam int unsigned GlyphBits   = GlyphWidth * GlyphHeight;

  localparam int unsigned FirstCode   = 32;
  localparam int unsigned GlyphCount  = 95;
  localparam int unsigned DigitBase   = 48;
  localparam int unsigned MaxDigits   = 10;

  localparam int unsigned RowW  = $clog2(GlyphHeight);
  localparam int unsigned PosW  = $clog2(MaxDigits);
  localparam int unsigned NdigW = $clog2(MaxDigits + 1);
  localparam int unsigned SpanW = $clog2(MaxDigits * GlyphPitch + 1);

  localparam int unsigned ValueW = 31;
  localparam int unsigned CoordW = 12;
  localparam int unsigned OutW   = 13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIGIT,
    ST_EMIT
  } state_e;

  // powers of ten used by the shared compare/subtract unit
  function automatic logic [ValueW-1:0] pow10(input logic [PosW-1:0] idx);
    logic [ValueW-1:0] p;
    unique case (idx)
      4'd0:    p = 31'd1;
      4'd1:    p = 31'd10;
      4'd2:    p = 31'd100;
      4'd3:    p = 31'd1000;
      4'd4:    p = 31'd10000;
      4'd5:    p = 31'd100000;
      4'd6:    p = 31'd1000000;
      4'd7:    p = 31'd10000000;
      4'd8:    p = 31'd100000000;
      4'd9:    p = 31'd1000000000;
      default: p = 31'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/gtr_glyph_rom.sv -----
module gtr_glyph_rom
  import gtr_pkg::*;
(
  input  logic [7:0]           code_i,
  output logic [GlyphBits-1:0] bits_o
);

  localparam int unsigned IdxW = $clog2(GlyphCount + 1);

  localparam logic [GlyphBits-1:0] GlyphRom [GlyphCount+1] = '{
    30'h00000000, 30'h08021084, 30'h0000014A, 30'h15F57D40, 30'h1F4717C4, 30'h22221111,
    30'h2C9A88A2, 30'h00000084, 30'h1821084C, 30'h0C842106, 30'h2AEFBAA0, 30'h084F9080,
    30'h04400000, 30'h00007C00, 30'h08000000, 30'h02221110, 30'h1D3AD72E, 30'h3E4214C4,
    30'h3E17420F, 30'h1F083A1F, 30'h108FA988, 30'h1F083C3F, 30'h1D18BC3E, 30'h0222221F,
    30'h1D18BA2E, 30'h1F0F462E, 30'h00400080, 30'h04401000, 30'h30609B00, 30'h01F07C00,
    30'h06C83060, 30'h0802322E, 30'h05DAF62E, 30'h23153944, 30'h1F18BE2F, 30'h3C10843E,
    30'h1F18C62F, 30'h3E109C3F, 30'h02109C3F, 30'h3D1C843E, 30'h2318FE31, 30'h3E42109F,
    30'h0C94A11E, 30'h22928CB9, 30'h3E108421, 30'h2318D771, 30'h239AD671, 30'h1D18C62E,
    30'h0217C62F, 30'h2C9AC62E, 30'h2297C62F, 30'h1F08383E, 30'h0842109F, 30'h1D18C631,
    30'h08A54631, 30'h23BAC631, 30'h23151151, 30'h08422A31, 30'h3E22111F, 30'h1C21084E,
    30'h20821041, 30'h1C84210E, 30'h00004544, 30'h3E000000, 30'h00000082, 30'h1CA721C0,
    30'h1CA53842, 30'h1C2109C0, 30'h1CA53908, 30'h1C2729C0, 30'h0842388C, 30'h1C8729C0,
    30'h14A53842, 30'h08421004, 30'h0C421004, 30'h14A32842, 30'h08421084, 30'h2B5AD560,
    30'h14A528C0, 30'h1CA529C0, 30'h042729C0, 30'h108729C0, 30'h04253840, 30'h1C8709C0,
    30'h0C4211C4, 30'h1CA52940, 30'h08452940, 30'h14AAD6A0, 30'h14A22940, 30'h1C872940,
    30'h1C2221C0, 30'h18210C4C, 30'h08421084, 30'h0C846106, 30'h009AC800, 30'h3FFFFFFF
  };

  logic [IdxW-1:0] idx;

  // non-printable codes fall on the solid invalid glyph at the end
  always_comb begin
    if (code_i >= 8'(FirstCode) && code_i < 8'(FirstCode + GlyphCount)) begin
      idx = IdxW'(code_i - 8'(FirstCode));
    end else begin
      idx = IdxW'(GlyphCount);
    end
  end

  assign bits_o = GlyphRom[idx];

endmodule

// ----- rtl/core/glyph_text_rasterizer.sv -----
// Character: the request is registered, then 6 row beats follow, one per cycle when out_ready_i is high.
// Number of n digits: the digits are first counted against rising powers of ten, then each digit is
// found by compare/subtract against its power of ten in the shared unit, then sent as 6 row beats.
// One request at a time: in_ready_o is high only while idle, after reset or once the last row beat has gone out.
// rst_ni is asynchronous, active low, and returns the sequencer to idle; payload is not reset.
module glyph_text_rasterizer
  import gtr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [7:0]        char_code_i,
  input  logic [ValueW-1:0] number_value_i,
  input  logic [CoordW-1:0] x_pos_i,
  input  logic [CoordW-1:0] y_pos_i,
  input  logic [7:0]        ink_color_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OutW-1:0]   row_x_o,
  output logic [OutW-1:0]   row_y_o,
  output logic [4:0]        row_mask_o,
  output logic [7:0]        row_color_o,
  output logic              last_row_o
);

  state_e state_q, state_d;

  logic              func_q, func_d;
  logic [7:0]        code_q, code_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [OutW-1:0]   x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [7:0]        color_q, color_d;
  logic [NdigW-1:0]  ndig_q, ndig_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [3:0]        digit_q, digit_d;
  logic [RowW-1:0]   row_q, row_d;

  logic              in_beat, out_beat;
  logic [ValueW-1:0] pw;
  logic              ge;
  logic [ValueW-1:0] diff;
  logic              count_more;
  logic [NdigW-1:0]  ndig_fin;
  logic [SpanW-1:0]  span;
  logic [SpanW-1:0]  half;
  logic              row_end;
  logic              glyph_last;
  logic [7:0]        glyph_code;
  logic [GlyphBits-1:0] glyph_bits;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // shared unit: one compare and one subtract against a power of ten
  assign pw   = pow10(pos_q);
  assign ge   = (rem_q >= pw);
  assign diff = rem_q - pw;

  assign count_more = ge && (pos_q != PosW'(MaxDigits - 1));
  assign ndig_fin   = ge ? ndig_q + NdigW'(1) : ndig_q;
  assign span       = SpanW'(ndig_fin) * SpanW'(GlyphPitch) - SpanW'(GlyphGap);
  assign half       = span >> 1;

  assign row_end    = (row_q == RowW'(GlyphHeight - 1));
  assign glyph_last = !func_q || (pos_q == '0);

  assign glyph_code = func_q ? 8'(DigitBase) + {4'd0, digit_q} : code_q;

  gtr_glyph_rom u_rom (
    .code_i (glyph_code),
    .bits_o (glyph_bits)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) state_d = func_i ? ST_COUNT : ST_EMIT;
      end
      ST_COUNT: begin
        if (!count_more) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (!ge) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_beat && row_end) state_d = glyph_last ? ST_IDLE : ST_DIGIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    func_d  = func_q;
    code_d  = code_q;
    rem_d   = rem_q;
    x_d     = x_q;
    y_d     = y_q;
    color_d = color_q;
    ndig_d  = ndig_q;
    pos_d   = pos_q;
    digit_d = digit_q;
    row_d   = row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          func_d  = func_i;
          code_d  = char_code_i;
          rem_d   = number_value_i;
          x_d     = {1'b0, x_pos_i};
          y_d     = y_pos_i;
          color_d = ink_color_i;
          ndig_d  = NdigW'(1);
          pos_d   = func_i ? PosW'(1) : '0;
          digit_d = '0;
          row_d   = '0;
        end
      end
      ST_COUNT: begin
        ndig_d = ndig_fin;
        if (count_more) begin
          pos_d = pos_q + PosW'(1);
        end else begin
          pos_d = PosW'(ndig_fin - NdigW'(1));
          // centre on x, or start at column 1 near the left edge
          if (x_q > OutW'(half)) x_d = x_q - OutW'(half);
          else                   x_d = OutW'(1);
        end
      end
      ST_DIGIT: begin
        if (ge) begin
          rem_d   = diff;
          digit_d = digit_q + 4'd1;
        end else begin
          row_d = '0;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          if (row_end) begin
            if (!glyph_last) begin
              pos_d   = pos_q - PosW'(1);
              digit_d = '0;
              x_d     = x_q + OutW'(GlyphPitch);
            end
          end else begin
            row_d = row_q + RowW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    code_q  <= code_d;
    rem_q   <= rem_d;
    x_q     <= x_d;
    y_q     <= y_d;
    color_q <= color_d;
    ndig_q  <= ndig_d;
    pos_q   <= pos_d;
    digit_q <= digit_d;
    row_q   <= row_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign row_x_o     = x_q;
  assign row_y_o     = {1'b0, y_q} + OutW'(row_q);
  assign row_mask_o  = glyph_bits[{2'b00, row_q} * 5'(GlyphWidth) +: GlyphWidth];
  assign row_color_o = color_q;
  assign last_row_o  = row_end && glyph_last;

endmodule

// ----- rtl/core/gtr_checker.sv -----
module gtr_checker
  import gtr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              func_i,
  input logic [CoordW-1:0] x_pos_i,
  input logic [CoordW-1:0] y_pos_i,
  input logic [7:0]        ink_color_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [OutW-1:0]   row_x_o,
  input logic [OutW-1:0]   row_y_o,
  input logic [4:0]        row_mask_o,
  input logic [7:0]        row_color_o,
  input logic              last_row_o
);

  // a stalled row beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_x_o) && $stable(row_y_o)
      && $stable(row_mask_o) && $stable(row_color_o) && $stable(last_row_o))
    else $error("row beat changed while stalled");

  // one request at a time: no intake while rows are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a row is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after taking a request");

  // the final row beat frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_row_o |=> in_ready_o && !out_valid_o)
    else $error("not idle after the last row");

  // a character request yields rows at the given column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !func_i |=> out_valid_o && row_x_o == {1'b0, $past(x_pos_i)}
      && row_y_o == {1'b0, $past(y_pos_i)} && row_color_o == $past(ink_color_i))
    else $error("character row does not match request");

endmodule

bind glyph_text_rasterizer gtr_checker u_gtr_checker (.*);
